// ===== sv/isq_pkg.sv =====
// Shared types and constants for the interpolated sine and square oscillator.
package isq_pkg;

  typedef enum logic [1:0] {
    CMD_SINE   = 2'd0,
    CMD_COSINE = 2'd1,
    CMD_SQUARE = 2'd2,
    CMD_ODD    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } ctl_t;

  localparam int SAMPLE_W = 18;
  localparam int SUM_W    = 20;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [18:0] RECIP3 = 19'sd87381;
  localparam logic signed [18:0] RECIP5 = 19'sd52429;
  localparam int RECIP_SHIFT = 18;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 20'sd131071;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -20'sd131072;

endpackage

// ===== sv/isq_phase.sv =====
// Input stage: cosine offset and wrapped third and fifth phase multiples.
module isq_phase import isq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  cmd,
  input  logic [31:0] phase_turns,
  output ctl_t        ctl,
  output logic [31:0] p1,
  output logic [31:0] p3,
  output logic [31:0] p5
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= accept;
    end
    ctl.cmd <= cmd_t'(cmd);
    if (cmd_t'(cmd) == CMD_COSINE) begin
      p1 <= phase_turns + QUARTER_TURN;
    end else begin
      p1 <= phase_turns;
    end
    // multiples wrap modulo one turn
    p3 <= phase_turns + {phase_turns[30:0], 1'b0};
    p5 <= phase_turns + {phase_turns[29:0], 2'b00};
  end

endmodule

// ===== sv/isq_lane.sv =====
// One interpolating sine lane: table read, slope multiply, rounding add.
module isq_lane import isq_pkg::*; #(
  parameter int TABLE_LOG2 = 10
) (
  input  logic                       clk,
  input  logic [31:0]                phase,
  output logic signed [SAMPLE_W-1:0] sine
);

  localparam int SIZE   = 1 << TABLE_LOG2;
  localparam int QTR    = SIZE / 4;
  localparam int FRAC_W = 32 - TABLE_LOG2;
  localparam int PROD_W = FRAC_W + 20;
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_W - 1);

  typedef logic signed [SAMPLE_W-1:0] rom_t [0:SIZE];

  // shift-and-subtract quotient, only evaluated while the table is built
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // first quadrant by integer Taylor series, Q1.16 result
  function automatic logic signed [SAMPLE_W-1:0] quarter_sine(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          q;
    int unsigned     n;
    x = (longint'(k) * HALF_PI_Q30) >> (TABLE_LOG2 - 2);
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (n = 1; n <= 9; n++) begin
      term = udiv((term * x2) >> 30, longint'(4 * n * n + 2 * n));
      if (n[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = longint'((longint'(acc) + 8192) >>> 14);
    if (q > 65536) begin
      q = 65536;
    end
    return SAMPLE_W'(q);
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    int unsigned quad;
    int unsigned k;
    for (int unsigned i = 0; i <= SIZE; i++) begin
      quad = (i >> (TABLE_LOG2 - 2)) & 3;
      k = i & (QTR - 1);
      case (quad)
        0:       rom[i] = quarter_sine(k);
        1:       rom[i] = quarter_sine(QTR - k);
        2:       rom[i] = -quarter_sine(k);
        default: rom[i] = -quarter_sine(QTR - k);
      endcase
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [TABLE_LOG2:0]         addr_l;
  logic [TABLE_LOG2:0]         addr_r;
  logic signed [SAMPLE_W-1:0]  left;
  logic signed [SAMPLE_W-1:0]  right;
  logic [FRAC_W-1:0]           frac;
  logic signed [SAMPLE_W:0]    diff;
  logic signed [PROD_W-1:0]    prod;
  logic signed [SAMPLE_W-1:0]  left_d;
  logic signed [PROD_W-1:0]    step;

  assign addr_l = {1'b0, phase[31:FRAC_W]};
  assign addr_r = addr_l + 1'b1;

  // stage 1: table read at both neighbours
  always_ff @(posedge clk) begin
    left  <= SINE_ROM[addr_l];
    right <= SINE_ROM[addr_r];
    frac  <= phase[FRAC_W-1:0];
  end

  assign diff = {right[SAMPLE_W-1], right} - {left[SAMPLE_W-1], left};

  // stage 2: slope times fraction
  always_ff @(posedge clk) begin
    prod   <= PROD_W'(diff * $signed({1'b0, frac}));
    left_d <= left;
  end

  // round half up, arithmetic shift floors
  assign step = (prod + HALF_LSB) >>> FRAC_W;

  // stage 3: interpolated value
  always_ff @(posedge clk) begin
    sine <= left_d + step[SAMPLE_W-1:0];
  end

endmodule

// ===== sv/isq_mix.sv =====
// Harmonic scaling by constant reciprocals, waveform select and saturation.
module isq_mix import isq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  ctl_t                       ctl_in,
  input  logic signed [SAMPLE_W-1:0] s1,
  input  logic signed [SAMPLE_W-1:0] s3,
  input  logic signed [SAMPLE_W-1:0] s5,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       done
);

  localparam int MUL_W = SAMPLE_W + 19;
  localparam logic signed [MUL_W-1:0] HALF_LSB = MUL_W'(1) << (RECIP_SHIFT - 1);

  ctl_t                       ctl_a;
  logic signed [SAMPLE_W-1:0] s1_a;
  logic signed [MUL_W-1:0]    m3;
  logic signed [MUL_W-1:0]    m5;
  logic signed [MUL_W-1:0]    m3_rnd;
  logic signed [MUL_W-1:0]    m5_rnd;
  logic signed [SUM_W-1:0]    h3;
  logic signed [SUM_W-1:0]    h5;
  logic signed [SUM_W-1:0]    fund;
  logic signed [SUM_W-1:0]    total;
  logic signed [SAMPLE_W-1:0] sample_next;

  // stage 1: reciprocal multiplies
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      ctl_a.valid <= ctl_in.valid;
      done        <= ctl_a.valid;
    end
    ctl_a.cmd <= ctl_in.cmd;
    s1_a      <= s1;
    m3        <= MUL_W'(s3 * RECIP3);
    m5        <= MUL_W'(s5 * RECIP5);
  end

  assign m3_rnd = (m3 + HALF_LSB) >>> RECIP_SHIFT;
  assign m5_rnd = (m5 + HALF_LSB) >>> RECIP_SHIFT;
  assign h3     = m3_rnd[SUM_W-1:0];
  assign h5     = m5_rnd[SUM_W-1:0];
  assign fund   = SUM_W'(s1_a);

  always_comb begin
    case (ctl_a.cmd)
      CMD_SINE, CMD_COSINE: total = fund;
      CMD_SQUARE:           total = fund + h3 + h5;
      CMD_ODD:              total = h3 + h5;
      default:              total = fund;
    endcase
    if (total > SUM_MAX) begin
      sample_next = SUM_MAX[SAMPLE_W-1:0];
    end else if (total < SUM_MIN) begin
      sample_next = SUM_MIN[SAMPLE_W-1:0];
    end else begin
      sample_next = total[SAMPLE_W-1:0];
    end
  end

  // stage 2: output register
  always_ff @(posedge clk) begin
    sample <= sample_next;
  end

endmodule

// ===== sv/interpolated_sine_and_square_osc.sv =====
// Top level of the interpolated sine, cosine and band-limited square oscillator.
//
//  channel  | handshake        | fields
//  ---------+------------------+-------------------------------
//  request  | start / busy     | cmd[1:0], phase_turns[31:0]
//  result   | done (1 cycle)   | sample[17:0] signed Q2.16
//
// One request per cycle while busy is low; each result passes in order through
// the pipeline stages phase prep, table read, slope multiply,
// interpolation, reciprocal multiply, select and saturate.
// busy is high only during reset; the sine table is a constant ROM, so no fill
// pass follows reset. Results cannot be held off, so nothing stalls.
module interpolated_sine_and_square_osc import isq_pkg::*; #(
  parameter int TABLE_LOG2 = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd,
  input  logic [31:0]                phase_turns,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       done
);

  localparam int LANE_STAGES = 3;

  ctl_t                       ctl_p;
  ctl_t                       ctl_d [LANE_STAGES];
  logic [31:0]                p1;
  logic [31:0]                p3;
  logic [31:0]                p5;
  logic signed [SAMPLE_W-1:0] s1;
  logic signed [SAMPLE_W-1:0] s3;
  logic signed [SAMPLE_W-1:0] s5;

  assign busy = rst;

  isq_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .accept      (start && !busy),
    .cmd         (cmd),
    .phase_turns (phase_turns),
    .ctl         (ctl_p),
    .p1          (p1),
    .p3          (p3),
    .p5          (p5)
  );

  isq_lane #(.TABLE_LOG2(TABLE_LOG2)) u_lane1 (.clk(clk), .phase(p1), .sine(s1));
  isq_lane #(.TABLE_LOG2(TABLE_LOG2)) u_lane3 (.clk(clk), .phase(p3), .sine(s3));
  isq_lane #(.TABLE_LOG2(TABLE_LOG2)) u_lane5 (.clk(clk), .phase(p5), .sine(s5));

  // control travels alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_STAGES; i++) begin
        ctl_d[i].valid <= 1'b0;
      end
    end else begin
      ctl_d[0].valid <= ctl_p.valid;
      for (int i = 1; i < LANE_STAGES; i++) begin
        ctl_d[i].valid <= ctl_d[i-1].valid;
      end
    end
    ctl_d[0].cmd <= ctl_p.cmd;
    for (int i = 1; i < LANE_STAGES; i++) begin
      ctl_d[i].cmd <= ctl_d[i-1].cmd;
    end
  end

  isq_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_d[LANE_STAGES-1]),
    .s1     (s1),
    .s3     (s3),
    .s5     (s5),
    .sample (sample),
    .done   (done)
  );

`ifndef ASSERT_OFF
  a_req_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("request without result");

  a_result_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result without request");

  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(cmd, 6) == CMD_SINE || $past(cmd, 6) == CMD_COSINE))
      |-> (sample <= 18'sd65536 && sample >= -18'sd65536))
    else $error("sine sample out of range");
`endif

endmodule

// ===== bench/isq_checker.sv =====
// Predicts and checks every sample produced by the interpolated sine and square oscillator.
module isq_checker import isq_pkg::*; #(
  parameter int TABLE_LOG2 = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 cmd,
  input  logic [31:0]                phase_turns,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       done,
  output int                         errors,
  output int                         outstanding,
  output int                         checked
);

  localparam int TABLE_SIZE = 1 << TABLE_LOG2;
  localparam int FRAC_BITS  = 32 - TABLE_LOG2;

  typedef struct {
    cmd_t                       cmd;
    logic [31:0]                phase;
    logic signed [SAMPLE_W-1:0] sample;
  } sample_expectation_t;

  longint              sine_table [0:TABLE_SIZE];
  sample_expectation_t expected_samples [$];
  int                  mismatch_count = 0;
  int                  checked_count  = 0;

  // First quadrant in Q1.16 from a ten-term Taylor series in Q2.30 integers.
  function automatic longint quarter_wave_sine(input int unsigned k);
    longint unsigned x, x2, term, n;
    longint          acc;
    x    = (longint'(k) * HALF_PI_Q30) >> (TABLE_LOG2 - 2);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= 9; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n[0]) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 8192) >>> 14;
    if (acc > 65536) acc = 65536;
    return acc;
  endfunction

  function automatic longint interp_sine(input logic [31:0] p);
    longint idx, f, left, right;
    idx   = longint'(p >> FRAC_BITS);
    f     = longint'(p) - (idx << FRAC_BITS);
    left  = sine_table[idx];
    right = sine_table[idx + 1];
    // arithmetic shift floors, so adding half first rounds ties upwards
    return left + (((right - left) * f + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
  endfunction

  function automatic longint scale_recip(input longint s, input longint recip);
    return (s * recip + (longint'(1) << (RECIP_SHIFT - 1))) >>> RECIP_SHIFT;
  endfunction

  function automatic longint odd_harmonics(input logic [31:0] p);
    logic [31:0] p3, p5;
    p3 = p * 32'd3;
    p5 = p * 32'd5;
    return scale_recip(interp_sine(p3), longint'(RECIP3)) +
           scale_recip(interp_sine(p5), longint'(RECIP5));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] predict_sample(input cmd_t c,
                                                                input logic [31:0] p);
    longint      r;
    logic [31:0] shifted;
    shifted = p + QUARTER_TURN;
    case (c)
      CMD_SINE:   r = interp_sine(p);
      CMD_COSINE: r = interp_sine(shifted);
      CMD_SQUARE: r = interp_sine(p) + odd_harmonics(p);
      default:    r = odd_harmonics(p);
    endcase
    if (r > longint'(SUM_MAX)) r = longint'(SUM_MAX);
    if (r < longint'(SUM_MIN)) r = longint'(SUM_MIN);
    return r[SAMPLE_W-1:0];
  endfunction

  initial begin
    int unsigned quad, k, q;
    q = TABLE_SIZE / 4;
    for (int unsigned i = 0; i <= TABLE_SIZE; i++) begin
      quad = (i >> (TABLE_LOG2 - 2)) & 3;
      k    = i & (q - 1);
      case (quad)
        0:       sine_table[i] = quarter_wave_sine(k);
        1:       sine_table[i] = quarter_wave_sine(q - k);
        2:       sine_table[i] = -quarter_wave_sine(k);
        default: sine_table[i] = -quarter_wave_sine(q - k);
      endcase
    end
  end

  always @(posedge clk) begin
    sample_expectation_t want;
    if (!rst) begin
      // compare before queuing, so a stray result never meets this edge's request
      if (done === 1'b1) begin
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected sample: expected none, got %0d", $time, sample);
        end else begin
          want = expected_samples.pop_front();
          checked_count++;
          if (sample !== want.sample) begin
            mismatch_count++;
            $display("%0t: sample mismatch for %s phase %h: expected %0d, got %0d",
                     $time, want.cmd.name(), want.phase, want.sample, sample);
          end
        end
      end
      if (start && !busy) begin
        want.cmd    = cmd_t'(cmd);
        want.phase  = phase_turns;
        want.sample = predict_sample(want.cmd, phase_turns);
        expected_samples.push_back(want);
      end
    end
    errors      <= mismatch_count;
    outstanding <= expected_samples.size();
    checked     <= checked_count;
  end

endmodule

// ===== bench/interpolated_sine_and_square_osc_tb.sv =====
// Stimulus and verdict for the interpolated sine and square oscillator.
module interpolated_sine_and_square_osc_tb;
  import isq_pkg::*;

  localparam int TABLE_LOG2   = 10;
  localparam int PHASE_FRAC_W = 32 - TABLE_LOG2;
  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 12;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 cmd = CMD_SINE;
  logic [31:0]                phase_turns = 32'd0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       done;

  int errors, outstanding, checked;
  int cmd_count [4] = '{0, 0, 0, 0};

  interpolated_sine_and_square_osc #(.TABLE_LOG2(TABLE_LOG2)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .phase_turns(phase_turns), .sample(sample), .done(done)
  );

  isq_checker #(.TABLE_LOG2(TABLE_LOG2)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .phase_turns(phase_turns), .sample(sample), .done(done),
    .errors(errors), .outstanding(outstanding), .checked(checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

  // holds the request until it is taken
  task automatic issue_request(input cmd_t c, input logic [31:0] p);
    start       <= 1'b1;
    cmd         <= c;
    phase_turns <= p;
    do @(posedge clk); while (busy);
    cmd_count[c]++;
  endtask

  // phases biased towards table points, interpolation ties and quadrant edges
  function automatic logic [31:0] pick_phase();
    logic [31:0] p;
    int unsigned kind;
    kind = $urandom_range(0, 19);
    p    = $urandom();
    if (kind < 3) begin
      case ($urandom_range(0, 3))
        0: p[31-TABLE_LOG2:0] = '0;
        1: p[31-TABLE_LOG2:0] = PHASE_FRAC_W'(1);
        2: p[31-TABLE_LOG2:0] = PHASE_FRAC_W'(1) << (PHASE_FRAC_W - 1);
        default: p[31-TABLE_LOG2:0] = '1;
      endcase
    end else if (kind < 5) begin
      p = {2'($urandom_range(0, 3)), 30'd0} + 32'($urandom_range(0, 64)) - 32'd32;
    end
    return p;
  endfunction

  initial begin
    logic [31:0] edge_phases [6];
    int          burst, sent;
    edge_phases = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h4000_0000,
                    32'h8000_0000, 32'hC000_0000, 32'h5555_5555};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every waveform at the turn ends, the quarter points and a wrapping multiple
    for (int c = 0; c < 4; c++)
      foreach (edge_phases[i]) issue_request(cmd_t'(c), edge_phases[i]);
    issue_request(CMD_SINE, 32'h0020_0000);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        issue_request(cmd_t'($urandom_range(0, 3)), pick_phase());
        sent++;
      end
      if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2) begin
        // let the pipeline run dry before carrying on
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end else if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Requests: %0d sine, %0d cosine, %0d square, %0d odd harmonics",
             cmd_count[CMD_SINE], cmd_count[CMD_COSINE], cmd_count[CMD_SQUARE],
             cmd_count[CMD_ODD]);
    $display("Samples checked: %0d, mismatches: %0d", checked, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
